@@ hw/rtl/lier_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lier_pkg
// Shared defaults, register indexes and operation codes of the isosurface
// edge root finder.
// ----------------------------------------------------------------------------
package lier_pkg;

  localparam int EXTEND_POINTS_DEF = 2;
  localparam int MAX_POINTS_DEF    = 6;
  localparam int COORD_BITS_DEF    = 10;
  localparam int FRAC_BITS_DEF     = 12;

  localparam int VALUE_BITS = 16;
  localparam int SCALE_BITS = 24;

  localparam logic [1:0] CFG_ISO_LEVEL       = 2'd0;
  localparam logic [1:0] CFG_ROOT_METHOD     = 2'd1;
  localparam logic [1:0] CFG_ITERATION_LIMIT = 2'd2;

  localparam logic [7:0] ITER_LIMIT_RESET = 8'd32;

  typedef enum logic [1:0] {
    OP_WEIGHT,
    OP_TERM,
    OP_FALSEPOS
  } op_e;

  typedef enum logic [1:0] {
    CTX_FA,
    CTX_FB,
    CTX_FC
  } ctx_e;

endpackage

@@ hw/rtl/lier_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lier_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lier_ram #(
  parameter int WIDTH = lier_pkg::VALUE_BITS + 3 * lier_pkg::COORD_BITS_DEF,
  parameter int DEPTH = lier_pkg::MAX_POINTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lagrange_isosurface_edge_root.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagrange_isosurface_edge_root
// Collects voxel samples along a cube edge line and finds the iso crossing on
// each axis by bisection or false position over a Lagrange polynomial.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid_i / in_stall_o | sample_value, pos_x/y/z, last
//  out     | output    | out_valid_o / out_stall_i | root_x/y/z, zero_divide
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  A sample without the last flag is accepted while the block is idle. A closing
//  sample starts the search: each polynomial evaluation over the n stored
//  samples runs on the bit-serial divider and the one multiplier, and each axis
//  needs up to iteration_limit+2 evaluations. Reset clears all control state;
//  the sample RAM is not cleared. A stalled result is held in the output
//  register while the next set is loaded.
// ----------------------------------------------------------------------------
module lagrange_isosurface_edge_root #(
  parameter int EXTEND_POINTS = lier_pkg::EXTEND_POINTS_DEF,
  parameter int MAX_POINTS    = lier_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS    = lier_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS     = lier_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_index_i,
  input  logic [15:0]                        cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [15:0]                 sample_value_i,
  input  logic [COORD_BITS-1:0]              pos_x_i,
  input  logic [COORD_BITS-1:0]              pos_y_i,
  input  logic [COORD_BITS-1:0]              pos_z_i,
  input  logic                               last_sample_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [COORD_BITS+FRAC_BITS-1:0]    root_x_o,
  output logic [COORD_BITS+FRAC_BITS-1:0]    root_y_o,
  output logic [COORD_BITS+FRAC_BITS-1:0]    root_z_o,
  output logic                               zero_divide_o
);

  localparam int CAP_EXT = 2 + 2 * EXTEND_POINTS;
  localparam int CAP     = (CAP_EXT < MAX_POINTS) ? CAP_EXT : MAX_POINTS;
  localparam int IDX_W   = $clog2(CAP);
  localparam int CNT_W   = $clog2(CAP + 1);
  localparam int VB      = lier_pkg::VALUE_BITS;
  localparam int SB      = lier_pkg::SCALE_BITS;
  localparam int SC_W    = SB + 1;
  localparam int WORD_W  = VB + 3 * COORD_BITS;
  localparam int ROOT_W  = COORD_BITS + FRAC_BITS;
  localparam int WMAG    = ((60 - ROOT_W) < 40) ? (60 - ROOT_W) : 40;
  localparam int MX_W    = (WMAG > SB) ? WMAG : SB;
  localparam int HALF    = (MX_W + 1) / 2;
  localparam int MY_W    = ((ROOT_W + 1) > SB) ? (ROOT_W + 1) : SB;
  localparam int PROD_W  = MX_W + MY_W;
  localparam int DVD_W   = PROD_W;
  localparam int DVS_W   = ((COORD_BITS + 1) > (SC_W + 1)) ? (COORD_BITS + 1) : (SC_W + 1);
  localparam int REM_W   = DVS_W + 1;
  localparam int DCNT_W  = $clog2(DVD_W);
  localparam int F_W     = WMAG + 21;
  localparam int CF_W    = DVD_W + 2;

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_AX_RD0  = 5'd1;
  localparam logic [4:0] S_AX_LD0  = 5'd2;
  localparam logic [4:0] S_AX_LD1  = 5'd3;
  localparam logic [4:0] S_AX_CHK  = 5'd4;
  localparam logic [4:0] S_AX_END  = 5'd5;
  localparam logic [4:0] S_IT      = 5'd6;
  localparam logic [4:0] S_SCALE   = 5'd7;
  localparam logic [4:0] S_FP_CHK  = 5'd8;
  localparam logic [4:0] S_E_RDJ   = 5'd9;
  localparam logic [4:0] S_E_LDJ   = 5'd10;
  localparam logic [4:0] S_E_K     = 5'd11;
  localparam logic [4:0] S_E_LDK   = 5'd12;
  localparam logic [4:0] S_MUL_LO  = 5'd13;
  localparam logic [4:0] S_MUL_HI  = 5'd14;
  localparam logic [4:0] S_MUL_END = 5'd15;
  localparam logic [4:0] S_DIV     = 5'd16;
  localparam logic [4:0] S_DIV_END = 5'd17;
  localparam logic [4:0] S_E_DONE  = 5'd18;
  localparam logic [4:0] S_FIN     = 5'd19;

  localparam logic [ROOT_W-1:0] ROOT_MAX = {ROOT_W{1'b1}};
  localparam logic [WMAG-1:0]   W_LIM    = {WMAG{1'b1}};
  localparam logic [DCNT_W-1:0] DCNT_END = DCNT_W'(DVD_W - 1);

  // Configuration
  logic signed [VB-1:0] iso_q;
  logic                 method_q;
  logic [7:0]           limit_q;

  // Control
  logic [4:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [1:0]           axis_q, axis_d;
  logic [CNT_W-1:0]     j_q, j_d, k_q, k_d;
  logic [7:0]           iter_q, iter_d;
  logic [DCNT_W-1:0]    dcnt_q, dcnt_d;
  lier_pkg::op_e        op_q, op_d;
  lier_pkg::ctx_e       ctx_q, ctx_d;
  logic                 zd_q, zd_d;
  logic                 out_valid_q, out_valid_d;

  // Datapath
  logic [ROOT_W-1:0]        a_q, a_d, b_q, b_d, c_q, c_d, t_q, t_d;
  logic [COORD_BITS-1:0]    lo_q, lo_d, hi_q, hi_d, xj_q, xj_d;
  logic signed [VB-1:0]     vj_q, vj_d;
  logic signed [WMAG:0]     w_q, w_d;
  logic signed [F_W-1:0]    sum_q, sum_d, fa_q, fa_d, fb_q, fb_d;
  logic [F_W-1:0]           ma_q, ma_d, mb_q, mb_d;
  logic                     fs_neg_q, fs_neg_d, fs_pos_q, fs_pos_d;
  logic [MX_W-1:0]          mx_q, mx_d;
  logic [MY_W-1:0]          my_q, my_d;
  logic                     msgn_q, msgn_d;
  logic [PROD_W-1:0]        prod_q, prod_d;
  logic [DVD_W-1:0]         dq_q, dq_d;
  logic [REM_W-1:0]         rem_q, rem_d;
  logic [DVS_W-1:0]         dvs_q, dvs_d;
  logic [ROOT_W-1:0]        roots_q [3];
  logic [ROOT_W-1:0]        roots_d [3];
  logic [ROOT_W-1:0]        rx_q, ry_q, rz_q;
  logic                     rzd_q;

  // RAM
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;
  logic [COORD_BITS-1:0]    rd_pos;

  // Shared multiplier
  logic [HALF-1:0]          mul_a;
  logic [HALF+MY_W-1:0]     mul_p;

  // Helper values
  logic                     in_acc;
  logic [CNT_W-1:0]         second;
  logic signed [ROOT_W:0]   d_s, bma_s;
  logic [ROOT_W:0]          d_mag, bma_mag;
  logic signed [COORD_BITS:0] den_s;
  logic [COORD_BITS:0]      den_mag;
  logic [WMAG:0]            w_mag;
  logic signed [VB:0]       vdiff_s;
  logic [VB:0]              vdiff_mag;
  logic signed [SC_W-1:0]   fap_s, fbp_s;
  logic signed [SC_W:0]     fdiff_s;
  logic [SC_W:0]            fdiff_mag;
  logic [F_W-1:0]           fa_abs, fb_abs;
  logic [REM_W-1:0]         rem_sh;
  logic                     rem_ge;
  logic [WMAG-1:0]          q_sat;
  logic signed [CF_W-1:0]   q_s, cf_s;
  logic [ROOT_W:0]          mid_sum;
  logic signed [F_W-1:0]    term_s;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign ram_we     = in_acc && (cnt_q < CNT_W'(CAP));
  assign second     = (cnt_q >= CNT_W'(2)) ? CNT_W'(1) : CNT_W'(0);

  lier_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAP)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i ({sample_value_i, pos_z_i, pos_y_i, pos_x_i}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    case (axis_q)
      2'd0:    rd_pos = ram_rdata[COORD_BITS-1:0];
      2'd1:    rd_pos = ram_rdata[2*COORD_BITS-1:COORD_BITS];
      default: rd_pos = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
    endcase
  end

  always_comb begin
    case (state_q)
      S_AX_LD0: ram_raddr = second[IDX_W-1:0];
      S_E_RDJ:  ram_raddr = j_q[IDX_W-1:0];
      S_E_K:    ram_raddr = k_q[IDX_W-1:0];
      default:  ram_raddr = '0;
    endcase
  end

  // One multiplier serves the weight product, the term product and the
  // false-position product, a half of the wide operand at a time.
  assign mul_a = (state_q == S_MUL_LO) ? mx_q[HALF-1:0] : HALF'(mx_q >> HALF);
  assign mul_p = (HALF+MY_W)'(mul_a) * (HALF+MY_W)'(my_q);

  always_comb begin
    d_s       = $signed({1'b0, t_q}) - $signed({1'b0, rd_pos, {FRAC_BITS{1'b0}}});
    d_mag     = d_s[ROOT_W] ? (ROOT_W+1)'(-d_s) : d_s;
    den_s     = $signed({1'b0, xj_q}) - $signed({1'b0, rd_pos});
    den_mag   = den_s[COORD_BITS] ? (COORD_BITS+1)'(-den_s) : den_s;
    w_mag     = w_q[WMAG] ? (WMAG+1)'(-w_q) : w_q;
    vdiff_s   = $signed({vj_q[VB-1], vj_q}) - $signed({iso_q[VB-1], iso_q});
    vdiff_mag = vdiff_s[VB] ? (VB+1)'(-vdiff_s) : vdiff_s;
    bma_s     = $signed({1'b0, b_q}) - $signed({1'b0, a_q});
    bma_mag   = bma_s[ROOT_W] ? (ROOT_W+1)'(-bma_s) : bma_s;
    fa_abs    = fa_q[F_W-1] ? F_W'(-fa_q) : fa_q;
    fb_abs    = fb_q[F_W-1] ? F_W'(-fb_q) : fb_q;
    fap_s     = fa_q[F_W-1] ? -$signed({1'b0, ma_q[SB-1:0]}) : $signed({1'b0, ma_q[SB-1:0]});
    fbp_s     = fb_q[F_W-1] ? -$signed({1'b0, mb_q[SB-1:0]}) : $signed({1'b0, mb_q[SB-1:0]});
    fdiff_s   = $signed({fap_s[SC_W-1], fap_s}) - $signed({fbp_s[SC_W-1], fbp_s});
    fdiff_mag = fdiff_s[SC_W] ? (SC_W+1)'(-fdiff_s) : fdiff_s;
    rem_sh    = {rem_q[REM_W-2:0], dq_q[DVD_W-1]};
    rem_ge    = (rem_sh >= REM_W'(dvs_q));
    q_sat     = (dq_q[DVD_W-1:WMAG] != '0) ? W_LIM : dq_q[WMAG-1:0];
    q_s       = msgn_q ? -$signed({2'b00, dq_q}) : $signed({2'b00, dq_q});
    cf_s      = $signed(CF_W'(a_q)) + q_s;
    mid_sum   = (ROOT_W+1)'(a_q) + (ROOT_W+1)'(b_q);
    term_s    = msgn_q ? -$signed({1'b0, prod_q[F_W-2:0]}) : $signed({1'b0, prod_q[F_W-2:0]});
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    axis_d      = axis_q;
    j_d         = j_q;
    k_d         = k_q;
    iter_d      = iter_q;
    dcnt_d      = dcnt_q;
    op_d        = op_q;
    ctx_d       = ctx_q;
    zd_d        = zd_q;
    out_valid_d = out_valid_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    t_d         = t_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    xj_d        = xj_q;
    vj_d        = vj_q;
    w_d         = w_q;
    sum_d       = sum_q;
    fa_d        = fa_q;
    fb_d        = fb_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    fs_neg_d    = fs_neg_q;
    fs_pos_d    = fs_pos_q;
    mx_d        = mx_q;
    my_d        = my_q;
    msgn_d      = msgn_q;
    prod_d      = prod_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    dvs_d       = dvs_q;
    roots_d     = roots_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (cnt_q < CNT_W'(CAP)) begin
            cnt_d = cnt_q + CNT_W'(1);
          end
          if (last_sample_i) begin
            axis_d  = 2'd0;
            zd_d    = 1'b0;
            state_d = S_AX_RD0;
          end
        end
      end
      S_AX_RD0: state_d = S_AX_LD0;
      S_AX_LD0: begin
        lo_d    = rd_pos;
        state_d = S_AX_LD1;
      end
      S_AX_LD1: begin
        hi_d    = rd_pos;
        state_d = S_AX_CHK;
      end
      S_AX_CHK: begin
        a_d    = {lo_q, {FRAC_BITS{1'b0}}};
        b_d    = {hi_q, {FRAC_BITS{1'b0}}};
        c_d    = {lo_q, {FRAC_BITS{1'b0}}};
        iter_d = '0;
        if (lo_q == hi_q || limit_q == 8'd0) begin
          state_d = S_AX_END;
        end else begin
          t_d     = {lo_q, {FRAC_BITS{1'b0}}};
          ctx_d   = lier_pkg::CTX_FA;
          sum_d   = '0;
          j_d     = '0;
          state_d = S_E_RDJ;
        end
      end
      S_AX_END: begin
        roots_d[axis_q] = c_q;
        if (axis_q == 2'd2) begin
          state_d = S_FIN;
        end else begin
          axis_d  = axis_q + 2'd1;
          state_d = S_AX_RD0;
        end
      end
      S_IT: begin
        if (iter_q == limit_q) begin
          state_d = S_AX_END;
        end else if (!method_q) begin
          if (a_q == b_q) begin
            state_d = S_AX_END;
          end else begin
            c_d      = mid_sum[ROOT_W:1];
            fs_neg_d = fa_q < 0;
            fs_pos_d = fa_q > 0;
            t_d      = mid_sum[ROOT_W:1];
            ctx_d    = lier_pkg::CTX_FC;
            sum_d    = '0;
            j_d      = '0;
            state_d  = S_E_RDJ;
          end
        end else begin
          ma_d    = fa_abs;
          mb_d    = fb_abs;
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        // Both end values shift together until the larger fits the scale width.
        if (((ma_q | mb_q) >> SB) != '0) begin
          ma_d = ma_q >> 1;
          mb_d = mb_q >> 1;
        end else begin
          state_d = S_FP_CHK;
        end
      end
      S_FP_CHK: begin
        if (fap_s == fbp_s) begin
          zd_d    = 1'b1;
          c_d     = a_q;
          state_d = S_AX_END;
        end else begin
          fs_neg_d = fap_s < 0;
          fs_pos_d = fap_s > 0;
          mx_d     = MX_W'(ma_q[SB-1:0]);
          my_d     = MY_W'(bma_mag);
          msgn_d   = bma_s[ROOT_W] ^ fap_s[SC_W-1] ^ fdiff_s[SC_W];
          dvs_d    = DVS_W'(fdiff_mag);
          op_d     = lier_pkg::OP_FALSEPOS;
          state_d  = S_MUL_LO;
        end
      end
      S_E_RDJ: state_d = S_E_LDJ;
      S_E_LDJ: begin
        xj_d    = rd_pos;
        vj_d    = ram_rdata[WORD_W-1:3*COORD_BITS];
        w_d     = (WMAG+1)'(1) <<< FRAC_BITS;
        k_d     = '0;
        state_d = S_E_K;
      end
      S_E_K: begin
        if (k_q == cnt_q) begin
          mx_d    = MX_W'(w_mag);
          my_d    = MY_W'(vdiff_mag);
          msgn_d  = w_q[WMAG] ^ vdiff_s[VB];
          op_d    = lier_pkg::OP_TERM;
          state_d = S_MUL_LO;
        end else if (k_q == j_q) begin
          k_d = k_q + CNT_W'(1);
        end else begin
          state_d = S_E_LDK;
        end
      end
      S_E_LDK: begin
        // Samples sharing the coordinate of sample j drop out of its weight.
        if (den_s == '0) begin
          k_d     = k_q + CNT_W'(1);
          state_d = S_E_K;
        end else begin
          mx_d    = MX_W'(w_mag);
          my_d    = MY_W'(d_mag);
          msgn_d  = w_q[WMAG] ^ d_s[ROOT_W] ^ den_s[COORD_BITS];
          dvs_d   = DVS_W'(den_mag);
          op_d    = lier_pkg::OP_WEIGHT;
          state_d = S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        prod_d  = PROD_W'(mul_p);
        state_d = S_MUL_HI;
      end
      S_MUL_HI: begin
        prod_d  = prod_q + (PROD_W'(mul_p) << HALF);
        state_d = S_MUL_END;
      end
      S_MUL_END: begin
        rem_d  = '0;
        dcnt_d = '0;
        case (op_q)
          lier_pkg::OP_TERM: begin
            sum_d = sum_q + term_s;
            j_d   = j_q + CNT_W'(1);
            if (j_q + CNT_W'(1) == cnt_q) begin
              state_d = S_E_DONE;
            end else begin
              state_d = S_E_RDJ;
            end
          end
          lier_pkg::OP_WEIGHT: begin
            // Truncating by the fraction first and then by the coordinate
            // difference gives the same quotient as one division.
            dq_d    = DVD_W'(prod_q >> FRAC_BITS);
            state_d = S_DIV;
          end
          default: begin
            dq_d    = DVD_W'(prod_q);
            state_d = S_DIV;
          end
        endcase
      end
      S_DIV: begin
        rem_d  = rem_ge ? (rem_sh - REM_W'(dvs_q)) : rem_sh;
        dq_d   = {dq_q[DVD_W-2:0], rem_ge};
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_END) begin
          state_d = S_DIV_END;
        end
      end
      S_DIV_END: begin
        if (op_q == lier_pkg::OP_WEIGHT) begin
          w_d     = msgn_q ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
          k_d     = k_q + CNT_W'(1);
          state_d = S_E_K;
        end else begin
          if (cf_s < 0) begin
            c_d = '0;
            t_d = '0;
          end else if (cf_s > $signed(CF_W'(ROOT_MAX))) begin
            c_d = ROOT_MAX;
            t_d = ROOT_MAX;
          end else begin
            c_d = cf_s[ROOT_W-1:0];
            t_d = cf_s[ROOT_W-1:0];
          end
          ctx_d   = lier_pkg::CTX_FC;
          sum_d   = '0;
          j_d     = '0;
          state_d = S_E_RDJ;
        end
      end
      S_E_DONE: begin
        case (ctx_q)
          lier_pkg::CTX_FA: begin
            fa_d = sum_q;
            if (method_q) begin
              t_d     = b_q;
              ctx_d   = lier_pkg::CTX_FB;
              sum_d   = '0;
              j_d     = '0;
              state_d = S_E_RDJ;
            end else begin
              state_d = S_IT;
            end
          end
          lier_pkg::CTX_FB: begin
            fb_d    = sum_q;
            state_d = S_IT;
          end
          default: begin
            if (sum_q == '0) begin
              state_d = S_AX_END;
            end else begin
              if ((sum_q < 0 && fs_pos_q) || (sum_q > 0 && fs_neg_q)) begin
                b_d  = c_q;
                fb_d = sum_q;
              end else begin
                a_d  = c_q;
                fa_d = sum_q;
              end
              iter_d  = iter_q + 8'd1;
              state_d = S_IT;
            end
          end
        endcase
      end
      S_FIN: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          cnt_d       = '0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iso_q       <= '0;
      method_q    <= 1'b0;
      limit_q     <= lier_pkg::ITER_LIMIT_RESET;
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      axis_q      <= '0;
      j_q         <= '0;
      k_q         <= '0;
      iter_q      <= '0;
      dcnt_q      <= '0;
      op_q        <= lier_pkg::OP_WEIGHT;
      ctx_q       <= lier_pkg::CTX_FA;
      zd_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          lier_pkg::CFG_ISO_LEVEL:       iso_q    <= cfg_data_i;
          lier_pkg::CFG_ROOT_METHOD:     method_q <= cfg_data_i[0];
          lier_pkg::CFG_ITERATION_LIMIT: limit_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      j_q         <= j_d;
      k_q         <= k_d;
      iter_q      <= iter_d;
      dcnt_q      <= dcnt_d;
      op_q        <= op_d;
      ctx_q       <= ctx_d;
      zd_q        <= zd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    t_q      <= t_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    xj_q     <= xj_d;
    vj_q     <= vj_d;
    w_q      <= w_d;
    sum_q    <= sum_d;
    fa_q     <= fa_d;
    fb_q     <= fb_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    fs_neg_q <= fs_neg_d;
    fs_pos_q <= fs_pos_d;
    mx_q     <= mx_d;
    my_q     <= my_d;
    msgn_q   <= msgn_d;
    prod_q   <= prod_d;
    dq_q     <= dq_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    roots_q  <= roots_d;
    if (state_q == S_FIN && !out_valid_q) begin
      rx_q  <= roots_q[0];
      ry_q  <= roots_q[1];
      rz_q  <= roots_q[2];
      rzd_q <= zd_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign root_x_o      = rx_q;
  assign root_y_o      = ry_q;
  assign root_z_o      = rz_q;
  assign zero_divide_o = rzd_q;

`ifndef SYNTHESIS
  a_zd_bisect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !method_q) |-> !zero_divide_o)
    else $error("zero_divide raised in bisection mode");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result presented without finishing the search");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IT) |-> (iter_q <= limit_q))
    else $error("iteration count passed the limit");

  a_eval_has_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_E_RDJ) |-> (j_q < cnt_q))
    else $error("evaluation reads beyond the stored samples");
`endif

endmodule
